// ----- rtl/assert_macros.svh -----
// assertion macros shared by the echo rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define FDTF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define FDTF_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- rtl/fdtf_pkg.sv -----
// types and constants of the stereo feedback echo
`default_nettype none

package fdtf_pkg;

   typedef struct packed {
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_WET,
      ST_DRY,
      ST_MIX,
      ST_TA,
      ST_TB,
      ST_FB,
      ST_ST,
      ST_DONE
   } state_type;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [1:0] CSR_DELAY    = 2'd0;
   localparam logic [1:0] CSR_FEEDBACK = 2'd1;
   localparam logic [1:0] CSR_MIX      = 2'd2;
   localparam logic [1:0] CSR_TONE     = 2'd3;

   localparam logic [23:0] DELAY_RESET    = 24'd3686400;
   localparam logic [14:0] FEEDBACK_RESET = 15'd9830;
   localparam logic [15:0] MIX_RESET      = 16'd8192;
   localparam logic [14:0] TONE_RESET     = 15'd11499;

   localparam int MUL_B_BITS = 17;
   localparam logic [16:0] COEF_ONE = 17'd32768;

endpackage

`default_nettype wire

// ----- rtl/feedback_delay_with_tone_filter.sv -----
// stereo feedback echo with low-pass in the loop, top level and sequencer
//
//   channel   direction   handshake                  contents
//   req       in          req_valid / req_stall      left and right input sample
//   rsp       out         rsp_valid / rsp_stall      left and right blended sample
//   csr       in / out    apb write and read         delay, feedback, mix, tone
//
// from accept to the next accept a frame runs one ring read step,
// then eight steps per channel through the single shared multiplier
// the result sits in an output register; the next frame is taken while it waits
// a frame finishing while the output register is still full waits for it
// after reset the rings read as zero through a fill count, with no clearing pass
`default_nettype none
`include "assert_macros.svh"

module feedback_delay_with_tone_filter #(
   parameter int RING_DEPTH = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire fdtf_pkg::req_type                      req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output fdtf_pkg::rsp_type                           rsp_data,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [fdtf_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  wire logic [fdtf_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic      [fdtf_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                        csr_pready
);

   import fdtf_pkg::*;

   localparam int RA  = $clog2(RING_DEPTH);
   localparam int S   = SAMPLE_BITS;
   localparam int WW  = S + 9;
   localparam int MAW = (WW > 24) ? WW : 24;
   localparam int PW  = MAW + MUL_B_BITS;
   localparam int ACW = PW + 1;
   localparam int CW  = ((RA + 8 > 24) ? RA + 8 : 24) + 1;

   localparam logic [CW-1:0] DLY_MIN  = CW'(256);
   localparam logic [CW-1:0] DLY_MAX  = CW'(RING_DEPTH - 2) << 8;
   localparam logic [RA:0]   DEPTH_W  = (RA + 1)'(RING_DEPTH);
   localparam logic [RA-1:0] LAST_IDX = RA'(RING_DEPTH - 1);

   localparam logic signed [ACW-1:0] RND15   = ACW'(16384);
   localparam logic signed [ACW-1:0] RND23   = ACW'(4194304);
   localparam logic signed [ACW-1:0] OUT_HI  = ACW'(32767);
   localparam logic signed [ACW-1:0] OUT_LO  = ACW'(-32768);
   localparam logic signed [ACW-1:0] TONE_HI = ACW'(8388607);
   localparam logic signed [ACW-1:0] TONE_LO = ACW'(-8388608);
   localparam logic signed [ACW-1:0] SMP_HI  = ACW'((1 <<< (S - 1)) - 1);
   localparam logic signed [ACW-1:0] SMP_LO  = ACW'(-(1 <<< (S - 1)));

   // configuration
   logic [23:0] delay_ff, delay_in;
   logic [14:0] feedback_ff, feedback_in;
   logic [15:0] mix_ff, mix_in;
   logic [14:0] tone_coef_ff, tone_coef_in;

   // control
   state_type state_ff, state_in;
   logic      ch_ff, ch_in;
   logic [RA-1:0] wp_ff, wp_in;
   logic      wrapped_ff, wrapped_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // datapath
   req_type   in_ff, in_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   logic [RA-1:0] i0_ff, i0_in, i1_ff, i1_in;
   logic [8:0] fr_ff, fr_in;
   logic      v0_ff, v0_in, v1_ff, v1_in;
   logic signed [WW-1:0]  wet_ff, wet_in;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic signed [15:0]    out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic signed [23:0]    tone_l_ff, tone_l_in, tone_r_ff, tone_r_in;

   // address decode
   logic [CW-1:0]    d_raw, d_clamp;
   logic [RA-1:0]    back, i0_calc, i1_calc;
   logic [RA:0]      sub;
   logic [7:0]       fd;

   // ring and multiplier
   logic [S-1:0] rd0_l, rd1_l, rd0_r, rd1_r;
   logic         ring_re, ring_we_l, ring_we_r;
   logic [S-1:0] st_val;
   logic signed [MAW-1:0]        op_a;
   logic signed [MUL_B_BITS-1:0] op_b;
   logic signed [PW-1:0]         prod;
   logic signed [ACW-1:0]        prod_ext;

   // per channel operands
   logic signed [S-1:0]   s0, s1;
   logic signed [S:0]     diff;
   logic signed [15:0]    in_smp;
   logic signed [23:0]    tone_cur;
   logic [16:0]           mix_eff, dry_coef, one_minus_a;
   logic signed [ACW-1:0] sum_o, o_sh, sum_t, t_sh, q_sh, st_full;

   logic csr_wr, req_acc, out_free;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_acc    = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   // register file
   always_comb begin
      delay_in     = delay_ff;
      feedback_in  = feedback_ff;
      mix_in       = mix_ff;
      tone_coef_in = tone_coef_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            CSR_DELAY:    delay_in     = csr_pwdata[23:0];
            CSR_FEEDBACK: feedback_in  = csr_pwdata[14:0];
            CSR_MIX:      mix_in       = csr_pwdata[15:0];
            CSR_TONE:     tone_coef_in = csr_pwdata[14:0];
            default:      delay_in     = delay_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_DELAY:    csr_prdata = 32'(delay_ff);
         CSR_FEEDBACK: csr_prdata = 32'(feedback_ff);
         CSR_MIX:      csr_prdata = 32'(mix_ff);
         CSR_TONE:     csr_prdata = 32'(tone_coef_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // read point from the delay setting
   always_comb begin
      d_raw = CW'(delay_ff);
      priority if (d_raw < DLY_MIN) begin
         d_clamp = DLY_MIN;
      end else if (d_raw > DLY_MAX) begin
         d_clamp = DLY_MAX;
      end else begin
         d_clamp = d_raw;
      end
      fd   = d_clamp[7:0];
      back = RA'(d_clamp[CW-1:8]) + RA'(fd != 8'd0);
      sub  = {1'b0, wp_ff} - {1'b0, back};
      i0_calc = sub[RA] ? RA'(sub + DEPTH_W) : sub[RA-1:0];
      i1_calc = (i0_calc == LAST_IDX) ? '0 : i0_calc + RA'(1);
   end

   // channel operands
   always_comb begin
      s0       = v0_ff ? (ch_ff ? rd0_r : rd0_l) : '0;
      s1       = v1_ff ? (ch_ff ? rd1_r : rd1_l) : '0;
      diff     = {s1[S-1], s1} - {s0[S-1], s0};
      in_smp   = ch_ff ? in_ff.right_in : in_ff.left_in;
      tone_cur = ch_ff ? tone_r_ff : tone_l_ff;
      mix_eff  = mix_ff[15] ? COEF_ONE : {1'b0, mix_ff};
      dry_coef = COEF_ONE - mix_eff;
      one_minus_a = COEF_ONE - {2'b00, tone_coef_ff};
      prod_ext = ACW'(prod);

      sum_o = acc_ff + prod_ext + RND23;
      o_sh  = sum_o >>> 23;
      sum_t = acc_ff + prod_ext;
      t_sh  = sum_t >>> 15;
      q_sh  = (prod_ext + RND23) >>> 23;
      st_full = ACW'(in_smp) + q_sh;
      priority if (st_full > SMP_HI) begin
         st_val = SMP_HI[S-1:0];
      end else if (st_full < SMP_LO) begin
         st_val = SMP_LO[S-1:0];
      end else begin
         st_val = st_full[S-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            state_in = ST_READ;
         end
         ST_READ: state_in = ST_DIFF;
         ST_DIFF: state_in = ST_WET;
         ST_WET:  state_in = ST_DRY;
         ST_DRY:  state_in = ST_MIX;
         ST_MIX:  state_in = ST_TA;
         ST_TA:   state_in = ST_TB;
         ST_TB:   state_in = ST_FB;
         ST_FB:   state_in = ST_ST;
         ST_ST:   state_in = ch_ff ? ST_DONE : ST_DIFF;
         ST_DONE: if (out_free) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath
   always_comb begin
      ch_in        = ch_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      in_in        = in_ff;
      i0_in        = i0_ff;
      i1_in        = i1_ff;
      fr_in        = fr_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      wet_in       = wet_ff;
      acc_in       = acc_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      tone_l_in    = tone_l_ff;
      tone_r_in    = tone_r_ff;
      op_a         = '0;
      op_b         = '0;
      ring_re      = 1'b0;
      ring_we_l    = 1'b0;
      ring_we_r    = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            in_in = req_data;
            ch_in = 1'b0;
            i0_in = i0_calc;
            i1_in = i1_calc;
            fr_in = (fd != 8'd0) ? 9'd256 - {1'b0, fd} : 9'd0;
         end
         ST_READ: begin
            ring_re = 1'b1;
            v0_in   = wrapped_ff | (i0_ff < wp_ff);
            v1_in   = wrapped_ff | (i1_ff < wp_ff);
         end
         ST_DIFF: begin
            op_a = MAW'(diff);
            op_b = MUL_B_BITS'({1'b0, fr_ff});
         end
         ST_WET: begin
            wet_in = (WW'(s0) <<< 8) + WW'(prod);
            op_a   = MAW'(in_smp);
            op_b   = dry_coef;
         end
         ST_DRY: begin
            acc_in = prod_ext <<< 8;
            op_a   = MAW'(wet_ff);
            op_b   = mix_eff;
         end
         ST_MIX: begin
            priority if (o_sh > OUT_HI) begin
               out_l_in = OUT_HI[15:0];
            end else if (o_sh < OUT_LO) begin
               out_l_in = OUT_LO[15:0];
            end else begin
               out_l_in = o_sh[15:0];
            end
            if (ch_ff) begin
               out_r_in = out_l_in;
               out_l_in = out_l_ff;
            end
            op_a = MAW'(wet_ff);
            op_b = one_minus_a;
         end
         ST_TA: begin
            acc_in = prod_ext + RND15;
            op_a   = MAW'(tone_cur);
            op_b   = {2'b00, tone_coef_ff};
         end
         ST_TB: begin
            priority if (t_sh > TONE_HI) begin
               tone_l_in = TONE_HI[23:0];
            end else if (t_sh < TONE_LO) begin
               tone_l_in = TONE_LO[23:0];
            end else begin
               tone_l_in = t_sh[23:0];
            end
            if (ch_ff) begin
               tone_r_in = tone_l_in;
               tone_l_in = tone_l_ff;
            end
         end
         ST_FB: begin
            op_a = MAW'(tone_cur);
            op_b = {2'b00, feedback_ff};
         end
         ST_ST: begin
            ring_we_l = ~ch_ff;
            ring_we_r = ch_ff;
            ch_in     = 1'b1;
         end
         ST_DONE: if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{left_out: out_l_ff, right_out: out_r_ff};
            wp_in        = (wp_ff == LAST_IDX) ? '0 : wp_ff + RA'(1);
            wrapped_in   = wrapped_ff | (wp_ff == LAST_IDX);
         end
         default: ch_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= 1'b0;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tone_l_ff    <= '0;
         tone_r_ff    <= '0;
         delay_ff     <= DELAY_RESET;
         feedback_ff  <= FEEDBACK_RESET;
         mix_ff       <= MIX_RESET;
         tone_coef_ff <= TONE_RESET;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
         tone_l_ff    <= tone_l_in;
         tone_r_ff    <= tone_r_in;
         delay_ff     <= delay_in;
         feedback_ff  <= feedback_in;
         mix_ff       <= mix_in;
         tone_coef_ff <= tone_coef_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      in_ff       <= in_in;
      i0_ff       <= i0_in;
      i1_ff       <= i1_in;
      fr_ff       <= fr_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      wet_ff      <= wet_in;
      acc_ff      <= acc_in;
      out_l_ff    <= out_l_in;
      out_r_ff    <= out_r_in;
   end

   fdtf_ring #(
      .DEPTH     (RING_DEPTH),
      .DATA_BITS (S)
   ) u_ring_l (
      .clock  (clock),
      .we     (ring_we_l),
      .waddr  (wp_ff),
      .wdata  (st_val),
      .re     (ring_re),
      .raddr0 (i0_ff),
      .raddr1 (i1_ff),
      .rdata0 (rd0_l),
      .rdata1 (rd1_l)
   );

   fdtf_ring #(
      .DEPTH     (RING_DEPTH),
      .DATA_BITS (S)
   ) u_ring_r (
      .clock  (clock),
      .we     (ring_we_r),
      .waddr  (wp_ff),
      .wdata  (st_val),
      .re     (ring_re),
      .raddr0 (i0_ff),
      .raddr1 (i1_ff),
      .rdata0 (rd0_r),
      .rdata1 (rd1_r)
   );

   fdtf_mul #(
      .A_BITS (MAW)
   ) u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   `FDTF_ASSERT(a_accept_reads, clock, reset, (req_valid && !req_stall) |=> (state_ff == ST_READ), "accepted request did not start a ring read")
   `FDTF_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "result raised outside the done step")
   `FDTF_NEVER(a_fill_holds, clock, reset, $fell(wrapped_ff), "ring fill mark dropped")

endmodule

`default_nettype wire

// ----- rtl/fdtf_ring.sv -----
// ring memory with one write port and two registered read ports
`default_nettype none

module fdtf_ring #(
   parameter int DEPTH = 65536,
   parameter int DATA_BITS = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [DATA_BITS-1:0] wdata,
   input  wire logic                 re,
   input  wire logic [ADDR_BITS-1:0] raddr0,
   input  wire logic [ADDR_BITS-1:0] raddr1,
   output logic      [DATA_BITS-1:0] rdata0,
   output logic      [DATA_BITS-1:0] rdata1
);

   logic [DATA_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata0 <= mem[raddr0];
         rdata1 <= mem[raddr1];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fdtf_mul.sv -----
// shared signed multiplier with registered product
`default_nettype none

module fdtf_mul #(
   parameter int A_BITS = 25
) (
   input  wire logic                                         clock,
   input  wire logic signed [A_BITS-1:0]                     op_a,
   input  wire logic signed [fdtf_pkg::MUL_B_BITS-1:0]       op_b,
   output logic      signed [A_BITS+fdtf_pkg::MUL_B_BITS-1:0] prod
);

   import fdtf_pkg::*;

   always_ff @(posedge clock) begin
      prod <= op_a * op_b;
   end

endmodule

`default_nettype wire

// ----- tb/feedback_delay_with_tone_filter_tb.sv -----
// self-checking bench for the stereo feedback echo: directed table, random phases, shadow predictor
`timescale 1ns / 100ps

module feedback_delay_with_tone_filter_tb;
   import fdtf_pkg::*;

   localparam int RING_SIZE = 65536;
   localparam longint DELAY_TOP = 64'd16776704;
   localparam longint TONE_MAX = 64'sd8388607;
   localparam longint TONE_MIN = -64'sd8388608;
   localparam int FRAME_TARGET = 1270;
   localparam int CYCLE_LIMIT = 500000;
   localparam int CALM_FIRST = 600;
   localparam int CALM_LAST = 800;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 300;

   typedef enum logic {ROW_FRAME, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   reg_idx;
      logic [31:0]  value;
      req_type      frame;
      logic         typed;
      rsp_type      known;
   } plan_row_type;

   localparam req_type NO_FRAME = '0;
   localparam rsp_type NO_RSP = '0;

   localparam plan_row_type PLAN [34] = '{
      // reset settings, the ring still reads as zero: out is three quarters of in
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0}},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sh7FFF, 16'sh8000}, 1'b1,
        '{16'sd24575, -16'sd24576}},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sh8000, 16'sh7FFF}, 1'b1,
        '{-16'sd24576, 16'sd24575}},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sd1, -16'sd1}, 1'b1, '{16'sd1, -16'sd1}},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sd16384, -16'sd16384}, 1'b1,
        '{16'sd12288, -16'sd12288}},
      // one sample back, full wet, high feedback of 31130, open filter
      '{ROW_REG, CSR_DELAY, 32'd256, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_REG, CSR_FEEDBACK, 32'd31130, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_REG, CSR_MIX, 32'd32768, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_REG, CSR_TONE, 32'd0, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sd20000, -16'sd20000}, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{-16'sd12345, 16'sd12345}, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sh7FFF, 16'sh7FFF}, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sh8000, 16'sh8000}, 1'b0, NO_RSP},
      // delay below range, wet share above one, filter pole at top, feedback at top
      '{ROW_REG, CSR_DELAY, 32'd0, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_REG, CSR_MIX, 32'd65535, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_REG, CSR_TONE, 32'd32767, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_REG, CSR_FEEDBACK, 32'd32767, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sh7FFF, 16'sh8000}, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sd0, 16'sd0}, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sd100, -16'sd100}, 1'b0, NO_RSP},
      // delay above range, dry only: out equals in
      '{ROW_REG, CSR_DELAY, 32'd16777215, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_REG, CSR_MIX, 32'd0, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_REG, CSR_FEEDBACK, 32'd0, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sh7FFF, 16'sh8000}, 1'b1, '{16'sh7FFF, 16'sh8000}},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sh8000, 16'sh7FFF}, 1'b1, '{16'sh8000, 16'sh7FFF}},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0}},
      // fractional delay of one and a half samples
      '{ROW_REG, CSR_DELAY, 32'd384, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_REG, CSR_MIX, 32'd16384, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_REG, CSR_TONE, 32'd11499, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_REG, CSR_FEEDBACK, 32'd16384, NO_FRAME, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sd10000, -16'sd10000}, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{-16'sd7000, 16'sd3000}, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sh7FFF, 16'sh8000}, 1'b0, NO_RSP},
      '{ROW_FRAME, CSR_DELAY, 32'd0, '{16'sd5, -16'sd5}, 1'b0, NO_RSP}
   };

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // shadow of the block's settings and memory
   logic [23:0] delay_cfg;
   logic [14:0] feedback_cfg;
   logic [15:0] mix_cfg;
   logic [14:0] tone_cfg;
   logic signed [15:0] echo_ring [2][RING_SIZE];
   logic signed [23:0] tone_mem [2];
   int write_pos;

   rsp_type pending_blends [$];
   int frames_sent;
   int frames_heard;
   int fail_count;
   int cycle_count;

   feedback_delay_with_tone_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   function automatic logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] echo_channel(int ch, logic signed [15:0] x,
                                                       int i0, int i1, longint fr);
      longint s0, s1, wet, a, mix, t, st, o;
      s0 = echo_ring[ch][i0];
      s1 = echo_ring[ch][i1];
      wet = s0 * 256 + (s1 - s0) * fr;
      a = longint'(tone_cfg);
      mix = (mix_cfg > 16'd32768) ? 64'sd32768 : longint'(mix_cfg);
      t = ((32768 - a) * wet + a * longint'(tone_mem[ch]) + 16384) >>> 15;
      if (t > TONE_MAX) t = TONE_MAX;
      if (t < TONE_MIN) t = TONE_MIN;
      tone_mem[ch] = t[23:0];
      st = longint'(x) + ((t * longint'(feedback_cfg) + 64'sd4194304) >>> 23);
      echo_ring[ch][write_pos] = sat16(st);
      o = (longint'(x) * 256 * (32768 - mix) + wet * mix + 64'sd4194304) >>> 23;
      return sat16(o);
   endfunction

   function automatic rsp_type echo_frame(req_type f);
      longint d, fr;
      int back, i0, i1;
      rsp_type r;
      d = longint'(delay_cfg);
      if (d < 256) d = 256;
      if (d > DELAY_TOP) d = DELAY_TOP;
      back = int'(d >> 8);
      fr = 0;
      if (d[7:0] != 8'd0) begin
         back++;
         fr = 256 - longint'(d[7:0]);
      end
      i0 = (write_pos + RING_SIZE - back) % RING_SIZE;
      i1 = (i0 + 1) % RING_SIZE;
      r.left_out = echo_channel(0, f.left_in, i0, i1, fr);
      r.right_out = echo_channel(1, f.right_in, i0, i1, fr);
      write_pos = (write_pos + 1) % RING_SIZE;
      return r;
   endfunction

   function automatic logic signed [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      if (r < 25) return 16'($urandom_range(0, 512) - 256);
      return 16'($urandom);
   endfunction

   task automatic send_frame(req_type f, logic typed, rsp_type known);
      rsp_type want;
      req_valid <= 1'b1;
      req_data <= f;
      do @(posedge clock); while (req_stall);
      want = echo_frame(f);
      pending_blends.push_back(typed ? known : want);
      frames_sent++;
      if ((frames_sent < CALM_FIRST || frames_sent >= CALM_LAST) &&
          $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 33);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_blends.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_DELAY:    delay_cfg = v[23:0];
         CSR_FEEDBACK: feedback_cfg = v[14:0];
         CSR_MIX:      mix_cfg = v[15:0];
         CSR_TONE:     tone_cfg = v[14:0];
         default:      ;
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_blend(rsp_type got);
      rsp_type want;
      frames_heard++;
      if (pending_blends.size() == 0) begin
         $error("unexpected result: left_out %0d right_out %0d", got.left_out, got.right_out);
         fail_count++;
      end else begin
         want = pending_blends.pop_front();
         if (got.left_out !== want.left_out) begin
            $error("left_out: expected %0d, actual %0d", want.left_out, got.left_out);
            fail_count++;
         end
         if (got.right_out !== want.right_out) begin
            $error("right_out: expected %0d, actual %0d", want.right_out, got.right_out);
            fail_count++;
         end
      end
   endtask

   // result side: random stall, one long hold-off, a calm stretch
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_blend(rsp_data);
         if (!held && frames_heard == HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            held = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (frames_heard >= CALM_FIRST && frames_heard < CALM_LAST) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 33);
         end
      end
   end

   initial begin
      int row;
      int phase_len;
      logic [31:0] v;
      req_type f;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      frames_sent = 0;
      frames_heard = 0;
      fail_count = 0;
      write_pos = 0;
      tone_mem[0] = '0;
      tone_mem[1] = '0;
      for (int i = 0; i < RING_SIZE; i++) begin
         echo_ring[0][i] = '0;
         echo_ring[1][i] = '0;
      end
      delay_cfg = DELAY_RESET;
      feedback_cfg = FEEDBACK_RESET;
      mix_cfg = MIX_RESET;
      tone_cfg = TONE_RESET;

      wait (!reset);
      @(posedge clock);

      for (row = 0; row < $size(PLAN); row++) begin
         if (PLAN[row].kind == ROW_REG) begin
            drain();
            csr_write(PLAN[row].reg_idx, PLAN[row].value);
         end else begin
            send_frame(PLAN[row].frame, PLAN[row].typed, PLAN[row].known);
         end
      end

      while (frames_sent < FRAME_TARGET) begin
         drain();
         case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 255);
            1:       v = $urandom_range(16776704, 16777215);
            2:       v = $urandom_range(1, 8) * 256;
            3, 4:    v = $urandom_range(64 * 256, 1200 * 256);
            default: v = $urandom_range(256, 64 * 256);
         endcase
         csr_write(CSR_DELAY, v);
         v = ($urandom_range(0, 4) == 0) ? $urandom_range(31131, 32767) : $urandom_range(0, 31130);
         csr_write(CSR_FEEDBACK, v);
         v = ($urandom_range(0, 4) == 0) ? $urandom_range(32769, 65535) : $urandom_range(0, 32768);
         csr_write(CSR_MIX, v);
         csr_write(CSR_TONE, $urandom_range(0, 32767));
         phase_len = $urandom_range(60, 140);
         if (phase_len > FRAME_TARGET - frames_sent) phase_len = FRAME_TARGET - frames_sent;
         repeat (phase_len) begin
            f.left_in = pick_sample();
            f.right_in = pick_sample();
            send_frame(f, 1'b0, NO_RSP);
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
